// File: rtl/core/nbpt_pkg.sv
package nbpt_pkg;

   localparam logic OP_ENTRY = 1'b0;
   localparam logic OP_END   = 1'b1;

   localparam logic CSR_DIST_THRESHOLD = 1'b0;
   localparam logic CSR_MAX_AGE        = 1'b1;

   localparam logic [16:0] SENTINEL_CM        = 17'd99900;
   localparam logic [16:0] RESET_THRESHOLD_CM = 17'd300;
   localparam logic [31:0] RESET_MAX_AGE_MS   = 32'd30000;

   typedef struct packed {
      logic        op;
      logic [47:0] beacon_address;
      logic [16:0] beacon_distance_cm;
      logic [31:0] age_ms;
      logic        in_filter;
   } req_type;

   typedef struct packed {
      logic [47:0] report_address;
      logic [16:0] report_distance_cm;
      logic        present;
      logic        last_of_run;
   } rsp_type;

   // reports produced by one end of scan, in order
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } emit_type;

endpackage

// File: rtl/core/nearest_beacon_presence_tracker_unit.sv
// Nearest-beacon presence tracker. One request is taken per cycle while
// req_stall is low. A taken request is registered in an input stage; an entry
// request updates the running scan state when it leaves that stage and gives
// no response, while an end-of-scan request then gives zero, one or two
// reports, written together into a report queue of 2**QUEUE_ADDR_BITS
// entries. Responses leave the queue one per cycle while rsp_stall is low;
// req_stall rises when a request waits in the input stage and the queue cannot
// hold two more reports. Configuration writes take effect at the next edge.
module nearest_beacon_presence_tracker_unit #(
   parameter int QUEUE_ADDR_BITS = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  nbpt_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output nbpt_pkg::rsp_type  rsp_data,
   input  logic               csr_write,
   input  logic               csr_index,
   input  logic [31:0]        csr_wdata
);
   import nbpt_pkg::*;

   logic [16:0] threshold_ff, threshold_in;
   logic [31:0] max_age_ff, max_age_in;
   logic        in_valid_ff, in_valid_in;
   req_type     in_data_ff, in_data_in;

   logic     room, advance, accept;
   emit_type emit;

   always_comb begin
      threshold_in = threshold_ff;
      max_age_in   = max_age_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_DIST_THRESHOLD: threshold_in = csr_wdata[16:0];
            CSR_MAX_AGE:        max_age_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      advance     = in_valid_ff && room;
      req_stall   = in_valid_ff && !room;
      accept      = req_valid && !req_stall;
      in_valid_in = accept || (in_valid_ff && !advance);
      in_data_in  = accept ? req_data : in_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= RESET_THRESHOLD_CM;
         max_age_ff   <= RESET_MAX_AGE_MS;
         in_valid_ff  <= 1'b0;
      end else begin
         threshold_ff <= threshold_in;
         max_age_ff   <= max_age_in;
         in_valid_ff  <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
   end

   nbpt_scan u_scan (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (advance),
      .item         (in_data_ff),
      .threshold_cm (threshold_ff),
      .max_age_ms   (max_age_ff),
      .emit         (emit)
   );

   nbpt_queue #(
      .ADDR_BITS (QUEUE_ADDR_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (advance),
      .emit      (emit),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_entry_silent: assert property (@(posedge clock) disable iff (reset)
      (advance && in_data_ff.op == OP_ENTRY) |-> emit.count == 2'd0)
      else $error("entry request produced a report");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      (advance && emit.count == 2'd2) |-> (!emit.first.last_of_run
         && emit.second.last_of_run))
      else $error("last_of_run misplaced in report pair");

   a_hold_pending: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_data_ff)))
      else $error("pending request lost while queue full");

endmodule

// File: rtl/core/nbpt_scan.sv
module nbpt_scan (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   input  nbpt_pkg::req_type   item,
   input  logic [16:0]         threshold_cm,
   input  logic [31:0]         max_age_ms,
   output nbpt_pkg::emit_type  emit
);
   import nbpt_pkg::*;

   logic [47:0] tracked_addr_ff, tracked_addr_in;
   logic        tracked_valid_ff, tracked_valid_in;
   logic        gone_reported_ff, gone_reported_in;
   logic [47:0] best_addr_ff, best_addr_in;
   logic [16:0] best_dist_ff, best_dist_in;
   logic        best_found_ff, best_found_in;
   logic        any_visible_ff, any_visible_in;
   logic        tracked_visible_ff, tracked_visible_in;
   logic        tracked_listed_ff, tracked_listed_in;
   logic [16:0] tracked_dist_ff, tracked_dist_in;

   logic vis, match, lost, back, gone_mid, change, vanish, first_grp, second_grp;

   always_comb begin
      vis = item.in_filter && (item.beacon_distance_cm <= threshold_cm)
            && (item.age_ms < max_age_ms);
      match = tracked_valid_ff && (item.beacon_address == tracked_addr_ff);

      lost = tracked_valid_ff && !tracked_visible_ff && !gone_reported_ff
             && tracked_listed_ff;
      back = tracked_valid_ff && tracked_visible_ff && gone_reported_ff;
      gone_mid = lost || (gone_reported_ff && !back);
      change = best_found_ff && (!tracked_valid_ff || (tracked_addr_ff != best_addr_ff));
      vanish = !best_found_ff && tracked_valid_ff && !any_visible_ff && !gone_mid
               && tracked_listed_ff;
      first_grp  = lost || back;
      second_grp = change || vanish;

      tracked_addr_in    = tracked_addr_ff;
      tracked_valid_in   = tracked_valid_ff;
      gone_reported_in   = gone_reported_ff;
      best_addr_in       = best_addr_ff;
      best_dist_in       = best_dist_ff;
      best_found_in      = best_found_ff;
      any_visible_in     = any_visible_ff;
      tracked_visible_in = tracked_visible_ff;
      tracked_listed_in  = tracked_listed_ff;
      tracked_dist_in    = tracked_dist_ff;

      emit = '0;

      if (item_valid) begin
         if (item.op == OP_ENTRY) begin
            if (vis) begin
               any_visible_in = 1'b1;
               if (item.beacon_distance_cm < best_dist_ff) begin
                  best_dist_in  = item.beacon_distance_cm;
                  best_addr_in  = item.beacon_address;
                  best_found_in = 1'b1;
               end
            end
            if (match) begin
               tracked_listed_in = 1'b1;
               tracked_dist_in   = item.beacon_distance_cm;
               if (vis) begin
                  tracked_visible_in = 1'b1;
               end
            end
         end else begin
            gone_reported_in = gone_mid;
            if (change) begin
               tracked_addr_in  = best_addr_ff;
               tracked_valid_in = 1'b1;
               gone_reported_in = 1'b0;
            end else if (vanish) begin
               gone_reported_in = 1'b1;
            end

            emit.second.report_address     = change ? best_addr_ff : tracked_addr_ff;
            emit.second.report_distance_cm = change ? best_dist_ff : tracked_dist_ff;
            emit.second.present            = change;
            emit.second.last_of_run        = 1'b1;

            if (first_grp) begin
               emit.first.report_address     = tracked_addr_ff;
               emit.first.report_distance_cm = tracked_dist_ff;
               emit.first.present            = back;
               emit.first.last_of_run        = !second_grp;
            end else begin
               emit.first = emit.second;
            end
            emit.count = 2'(first_grp) + 2'(second_grp);

            best_addr_in       = '0;
            best_dist_in       = SENTINEL_CM;
            best_found_in      = 1'b0;
            any_visible_in     = 1'b0;
            tracked_visible_in = 1'b0;
            tracked_listed_in  = 1'b0;
            tracked_dist_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tracked_addr_ff    <= '0;
         tracked_valid_ff   <= 1'b0;
         gone_reported_ff   <= 1'b0;
         best_addr_ff       <= '0;
         best_dist_ff       <= SENTINEL_CM;
         best_found_ff      <= 1'b0;
         any_visible_ff     <= 1'b0;
         tracked_visible_ff <= 1'b0;
         tracked_listed_ff  <= 1'b0;
         tracked_dist_ff    <= '0;
      end else begin
         tracked_addr_ff    <= tracked_addr_in;
         tracked_valid_ff   <= tracked_valid_in;
         gone_reported_ff   <= gone_reported_in;
         best_addr_ff       <= best_addr_in;
         best_dist_ff       <= best_dist_in;
         best_found_ff      <= best_found_in;
         any_visible_ff     <= any_visible_in;
         tracked_visible_ff <= tracked_visible_in;
         tracked_listed_ff  <= tracked_listed_in;
         tracked_dist_ff    <= tracked_dist_in;
      end
   end

endmodule

// File: rtl/core/nbpt_queue.sv
module nbpt_queue #(
   parameter int ADDR_BITS = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  nbpt_pkg::emit_type  emit,
   output logic                room,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output nbpt_pkg::rsp_type   rsp_data
);
   import nbpt_pkg::*;

   localparam int Depth = 1 << ADDR_BITS;
   localparam logic [ADDR_BITS:0] FillLimit = (ADDR_BITS + 1)'(Depth - 2);

   rsp_type mem_ff [Depth];

   logic [ADDR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ADDR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ADDR_BITS:0]   count_ff, count_in;
   logic [1:0]           push_n;
   logic                 pop;

   always_comb begin
      push_n    = push ? emit.count : 2'd0;
      rsp_valid = (count_ff != '0);
      pop       = rsp_valid && !rsp_stall;
      rsp_data  = mem_ff[rd_ptr_ff];
      room      = ((count_ff - (ADDR_BITS + 1)'(pop)) <= FillLimit);
      wr_ptr_in = wr_ptr_ff + ADDR_BITS'(push_n);
      rd_ptr_in = rd_ptr_ff + ADDR_BITS'(pop);
      count_in  = count_ff + (ADDR_BITS + 1)'(push_n) - (ADDR_BITS + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         mem_ff[wr_ptr_ff] <= emit.first;
      end
      if (push_n == 2'd2) begin
         mem_ff[wr_ptr_ff + ADDR_BITS'(1)] <= emit.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
